// File: rtl/core/mrpt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mrpt_pkg - shared constants for the Miller-Rabin prime test
// Holds the trial-division primes, the witness bases and the default width.
// ============================================================================
package mrpt_pkg;

    localparam int NUM_WIDTH_DEF = 64;
    localparam int NUM_PRIMES    = 12;
    localparam int PRIME_BITS    = 6;
    localparam int NUM_BASES     = 7;
    localparam int BASE_BITS     = 31;

    localparam logic [PRIME_BITS-1:0] SMALL_PRIMES [NUM_PRIMES] = '{
        6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19,
        6'd23, 6'd29, 6'd31, 6'd37
    };

    localparam logic [BASE_BITS-1:0] MR_BASES [NUM_BASES] = '{
        31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504,
        31'd1795265022
    };

endpackage

// File: rtl/core/miller_rabin_prime_test.sv
`timescale 1ns / 1ps
// ============================================================================
// miller_rabin_prime_test - deterministic 64-bit primality test
// Trial division by the primes 2..37, then strong probable-prime rounds to
// seven fixed bases. All wide arithmetic runs bit-serially.
// ============================================================================
//  channel | valid      | stall       | payload
//  --------+------------+-------------+-------------------------
//  in      | i_in_valid | o_in_stall  | i_candidate [63:0]
//  out     | o_out_valid| i_out_stall | o_prime_flag
//
//  Steps: trial division, splitting n-1, then per base a base reduction and
//  one modular product for each squaring and each set exponent bit (at most
//  about 2*W products). The shared bit-serial multiplier dominates the time
//  of a base round; numbers caught by trial division finish far sooner.
//  One candidate is in work at a time; o_in_stall is high while it runs.
//  The result sits in an output register, so the next transaction is taken
//  while the result still waits under i_out_stall.
//  Reset is synchronous, active low, and clears r_state, r_mstart and r_ov.
// ============================================================================
module miller_rabin_prime_test #(
    parameter int NUM_WIDTH = mrpt_pkg::NUM_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_candidate,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_prime_flag
);
    localparam int W   = NUM_WIDTH;
    localparam int CW  = $clog2(W + 1);
    localparam int SW  = $clog2(W);
    localparam int BCW = $clog2(mrpt_pkg::BASE_BITS + 1);
    localparam int NP  = mrpt_pkg::NUM_PRIMES;
    localparam int PB  = mrpt_pkg::PRIME_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_TRIAL, S_TDEC, S_SPLIT, S_RED, S_RDEC, S_PA, S_PAW,
        S_PB, S_PBW, S_CHK, S_SQ, S_SQW, S_NXT, S_FIN
    } t_state;

    t_state          r_state;
    logic [W-1:0]    r_n, r_nm1, r_d, r_e, r_acc, r_b, r_red, r_mx, r_my;
    logic [PB-1:0]   r_rem [NP];
    logic [CW-1:0]   r_cnt;
    logic [SW-1:0]   r_s, r_r;
    logic [2:0]      r_bi;
    logic [mrpt_pkg::BASE_BITS-1:0] r_bsh;
    logic [BCW-1:0]  r_bcnt;
    logic            r_mstart, r_res, r_ov, r_flag;

    logic            m_done;
    logic [W-1:0]    m_prod;
    logic [PB-1:0]   n_rem [NP];
    logic            n_div, n_eq;
    logic [W:0]      n_t;
    logic [W-1:0]    n_red;
    logic            n_mstart, n_ov;

    mrpt_modmul #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_n),
        .o_done  (m_done),
        .o_prod  (m_prod)
    );

    // advance every small-prime remainder by one bit of n, top bit first
    always_comb begin
        logic [PB:0] t;
        n_div = 1'b0;
        n_eq  = 1'b0;
        for (int i = 0; i < NP; i++) begin
            t = {r_rem[i], r_d[W-1]};
            n_rem[i] = (t >= {1'b0, mrpt_pkg::SMALL_PRIMES[i]})
                ? PB'(t - {1'b0, mrpt_pkg::SMALL_PRIMES[i]}) : t[PB-1:0];
            n_div = n_div | (r_rem[i] == '0);
            n_eq  = n_eq | (r_n == W'(mrpt_pkg::SMALL_PRIMES[i]));
        end
    end

    // reduce the base mod n one bit per cycle
    assign n_t   = {r_red, r_bsh[mrpt_pkg::BASE_BITS-1]};
    assign n_red = (n_t >= {1'b0, r_n}) ? W'(n_t - {1'b0, r_n}) : n_t[W-1:0];

    // kick the multiplier for a set exponent bit, a base squaring or a round squaring
    assign n_mstart = (r_state == S_PA && r_e != '0 && r_e[0])
                   || (r_state == S_PB)
                   || (r_state == S_SQ && r_r < r_s);

    // load the output register from S_FIN, hold it while stalled, drop it when taken
    assign n_ov = (r_state == S_FIN) || (r_ov && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_mstart <= n_mstart;
            r_ov     <= n_ov;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n   <= i_candidate[W-1:0];
                        r_d   <= i_candidate[W-1:0];
                        r_cnt <= CW'(W);
                        for (int i = 0; i < NP; i++) begin
                            r_rem[i] <= '0;
                        end
                        r_state <= S_TRIAL;
                    end
                end
                S_TRIAL: begin
                    r_rem <= n_rem;
                    r_d   <= r_d << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_TDEC;
                    end
                end
                S_TDEC: begin
                    if (r_n < W'(2)) begin
                        r_res   <= 1'b0;
                        r_state <= S_FIN;
                    end else if (n_div) begin
                        r_res   <= n_eq;
                        r_state <= S_FIN;
                    end else begin
                        r_d     <= r_n - W'(1);
                        r_nm1   <= r_n - W'(1);
                        r_s     <= '0;
                        r_bi    <= 3'd7;
                        r_state <= S_SPLIT;
                    end
                end
                S_SPLIT: begin
                    if (!r_d[0]) begin
                        r_d <= r_d >> 1;
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_state <= S_NXT;
                    end
                end
                S_NXT: begin
                    // r_bi starts at all ones so the first advance lands on base zero
                    if (r_bi == 3'(mrpt_pkg::NUM_BASES - 1)) begin
                        r_res   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_bi    <= r_bi + 1'b1;
                        r_bsh   <= mrpt_pkg::MR_BASES[r_bi + 1'b1];
                        r_bcnt  <= BCW'(mrpt_pkg::BASE_BITS);
                        r_red   <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    r_red  <= n_red;
                    r_bsh  <= r_bsh << 1;
                    r_bcnt <= r_bcnt - 1'b1;
                    if (r_bcnt == BCW'(1)) begin
                        r_state <= S_RDEC;
                    end
                end
                S_RDEC: begin
                    if (r_red == '0) begin
                        r_state <= S_NXT;
                    end else begin
                        r_b     <= r_red;
                        r_e     <= r_d;
                        r_acc   <= W'(1);
                        r_state <= S_PA;
                    end
                end
                S_PA: begin
                    if (r_e == '0) begin
                        r_state <= S_CHK;
                    end else if (r_e[0]) begin
                        r_mx     <= r_acc;
                        r_my     <= r_b;
                        r_state  <= S_PAW;
                    end else begin
                        r_state <= S_PB;
                    end
                end
                S_PAW: begin
                    if (m_done) begin
                        r_acc   <= m_prod;
                        r_state <= S_PB;
                    end
                end
                S_PB: begin
                    r_mx     <= r_b;
                    r_my     <= r_b;
                    r_state  <= S_PBW;
                end
                S_PBW: begin
                    if (m_done) begin
                        r_b     <= m_prod;
                        r_e     <= r_e >> 1;
                        r_state <= S_PA;
                    end
                end
                S_CHK: begin
                    if (r_acc == W'(1) || r_acc == r_nm1) begin
                        r_state <= S_NXT;
                    end else begin
                        r_r     <= SW'(1);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_r >= r_s) begin
                        r_res   <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_mx     <= r_acc;
                        r_my     <= r_acc;
                        r_state  <= S_SQW;
                    end
                end
                S_SQW: begin
                    if (m_done) begin
                        r_acc <= m_prod;
                        if (m_prod == r_nm1) begin
                            r_state <= S_NXT;
                        end else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_FIN: begin
                    // hold the verdict until the output register frees up
                    if (!r_ov || !i_out_stall) begin
                        r_flag  <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_prime_flag = r_flag;

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken twice in a row");
    a_base_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RED || r_state == S_PA || r_state == S_SQ)
        |-> r_bi < 3'(mrpt_pkg::NUM_BASES))
        else $error("base index out of range");
    a_residue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHK |-> r_acc < r_n)
        else $error("power result not reduced");
endmodule

// File: rtl/core/mrpt_modmul.sv
`timescale 1ns / 1ps
// ============================================================================
// mrpt_modmul - bit-serial modular multiplier
// Double-and-add from the top bit of y; each bit has a double phase and then
// an add phase. Operands must be below m.
// ============================================================================
module mrpt_modmul #(
    parameter int W = mrpt_pkg::NUM_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_x,
    input  logic [W-1:0] i_y,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, r_x, r_y, r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_phase, r_done;
    logic [W-1:0]  n_addend;
    logic [W:0]    n_sum;
    logic [W-1:0]  n_mod;
    logic          n_done;

    // one modular add per cycle: double, or add x
    assign n_addend = r_phase ? r_x : r_acc;
    assign n_sum    = {1'b0, r_acc} + {1'b0, n_addend};
    assign n_mod    = (n_sum >= {1'b0, r_m}) ? W'(n_sum - {1'b0, r_m}) : n_sum[W-1:0];

    // pulse done after the add cycle of the last bit
    assign n_done   = !i_start && r_busy && r_phase && (r_cnt == CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= n_done;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CW'(W);
                r_acc   <= '0;
                r_x     <= i_x;
                r_y     <= i_y;
                r_m     <= i_m;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (!r_phase) begin
                    r_acc <= n_mod;
                end else begin
                    if (r_y[W-1]) begin
                        r_acc <= n_mod;
                    end
                    r_y   <= r_y << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_acc_below_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start |-> r_acc < r_m)
        else $error("modmul accumulator left the residue range");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("modmul done without work");
    a_no_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("modmul done while busy");
endmodule
